// ===== rtl/bdsl_pkg.sv =====
// Shared types and codes for the bounded deque shift list.
package bdsl_pkg;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_BACK  = 3'd3,
    OP_CLEAR     = 3'd4,
    OP_READ      = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } sts_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic take;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic rd_last;
    logic slot_free;
  } stat_t;

endpackage

// ===== rtl/bdsl_if.sv =====
// Request and result channel interfaces.
interface bdsl_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [31:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface bdsl_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] data;
  logic               last;
  logic               is_full;
  logic               is_empty;

  modport source (output valid, output status, output data, output last,
                  output is_full, output is_empty, input ready);
  modport sink   (input valid, input status, input data, input last,
                  input is_full, input is_empty, output ready);
endinterface

// ===== rtl/bounded_deque_shift_list_top.sv =====
// Top level of the bounded deque shift list.
//
// in_ch carries one request per transfer: op and value. out_ch returns
// results with status, data, last, is_full and is_empty.
// Insert, remove, clear and unused codes give one result, registered in the
// cycle after the request is taken; one such request can be taken every
// cycle while out_ch keeps up.
// Read-out on a list with N entries takes the request, then gives N results,
// one per cycle while out_ch keeps up, from the front cell while the shift
// line rotates; the next request is taken after the last one leaves the
// controller. On an empty list read-out gives a single result marked empty.
// A single result register sits on out_ch; when the receiver stalls, the
// result holds and in_ch.ready drops until the register frees up.
// Reset (synchronous, rst_n low) empties the list and drops out_ch.valid.
module bounded_deque_shift_list_top import bdsl_pkg::*; #(
  parameter int CAPACITY = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  bdsl_in_if.sink    in_ch,
  bdsl_out_if.source out_ch
);

  cmd_t  cmd;
  stat_t stat;

  bdsl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .stat     (stat),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  bdsl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_op        (in_ch.op),
    .in_value     (in_ch.value),
    .cmd          (cmd),
    .out_ready    (out_ch.ready),
    .stat         (stat),
    .out_valid    (out_ch.valid),
    .out_status   (out_ch.status),
    .out_data     (out_ch.data),
    .out_last     (out_ch.last),
    .out_is_full  (out_ch.is_full),
    .out_is_empty (out_ch.is_empty)
  );

  a_take_emit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.take && cmd.emit))
    else $error("take and emit in the same cycle");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("read-out result would overwrite a pending result");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && op_t'(in_ch.op) != OP_READ) |=>
      (out_ch.valid && out_ch.last))
    else $error("missing single result after request");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.is_full && out_ch.is_empty))
    else $error("full and empty flags both set");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && sts_t'(out_ch.status) != STS_OK) |-> out_ch.last)
    else $error("error result not marked last");

endmodule

// ===== rtl/bdsl_ctrl.sv =====
// Controller: accepts requests and sequences the read-out.
module bdsl_ctrl import bdsl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_op,
  input  stat_t      stat,
  output logic       in_ready,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = stat.slot_free;
        if (in_valid && stat.slot_free) begin
          cmd.take = 1'b1;
          if (op_t'(in_op) == OP_READ && !stat.empty) begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (stat.slot_free) begin
          cmd.emit = 1'b1;
          if (stat.rd_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bdsl_dp.sv =====
// Datapath: shift-register cells, entry count, read counter, result register.
module bdsl_dp import bdsl_pkg::*; #(
  parameter int CAPACITY = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_op,
  input  logic signed [31:0] in_value,
  input  cmd_t               cmd,
  input  logic               out_ready,
  output stat_t              stat,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_data,
  output logic               out_last,
  output logic               out_is_full,
  output logic               out_is_empty
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] cell_r [CAPACITY];
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      rd_cnt_r, rd_cnt_nxt;
  logic               full, empty;
  op_t                op;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic signed [31:0] out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_full_r, out_empty_r;
  logic               load;

  assign op    = op_t'(in_op);
  assign full  = (count_r == CW'(CAPACITY));
  assign empty = (count_r == '0);

  assign stat.empty     = empty;
  assign stat.rd_last   = (rd_cnt_r == count_r - CW'(1));
  assign stat.slot_free = !out_valid_r || out_ready;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] up_src, dn_src, cell_nxt;

    if (i == 0) begin : g_up_head
      assign up_src = in_value;
    end else begin : g_up_body
      assign up_src = cell_r[i-1];
    end

    if (i == CAPACITY - 1) begin : g_dn_tail
      assign dn_src = cell_r[i];
    end else begin : g_dn_body
      assign dn_src = cell_r[i+1];
    end

    always_comb begin
      cell_nxt = cell_r[i];
      if (cmd.emit) begin
        // rotate the stored entries one place toward the front
        if (count_r == CW'(i + 1)) begin
          cell_nxt = cell_r[0];
        end else begin
          cell_nxt = dn_src;
        end
      end else if (cmd.take) begin
        case (op)
          OP_INS_FRONT: begin
            if (!full) begin
              cell_nxt = up_src;
            end
          end
          OP_INS_BACK: begin
            if (!full && count_r == CW'(i)) begin
              cell_nxt = in_value;
            end
          end
          OP_REM_FRONT: begin
            if (!empty) begin
              cell_nxt = dn_src;
            end
          end
          default: begin
            cell_nxt = cell_r[i];
          end
        endcase
      end
    end

    always_ff @(posedge clk) begin
      cell_r[i] <= cell_nxt;
    end
  end

  always_comb begin
    count_nxt      = count_r;
    rd_cnt_nxt     = rd_cnt_r;
    out_status_nxt = STS_OK;
    out_data_nxt   = '0;
    out_last_nxt   = 1'b1;
    load           = 1'b0;
    if (cmd.emit) begin
      load         = 1'b1;
      out_data_nxt = cell_r[0];
      out_last_nxt = stat.rd_last;
      rd_cnt_nxt   = rd_cnt_r + CW'(1);
    end else if (cmd.take) begin
      load = 1'b1;
      case (op)
        OP_INS_FRONT, OP_INS_BACK: begin
          if (full) begin
            out_status_nxt = STS_FULL;
          end else begin
            count_nxt = count_r + CW'(1);
          end
        end
        OP_REM_FRONT, OP_REM_BACK: begin
          if (empty) begin
            out_status_nxt = STS_EMPTY;
          end else begin
            count_nxt = count_r - CW'(1);
          end
        end
        OP_CLEAR: begin
          if (empty) begin
            out_status_nxt = STS_EMPTY;
          end else begin
            count_nxt = '0;
          end
        end
        OP_READ: begin
          rd_cnt_nxt = '0;
          if (empty) begin
            out_status_nxt = STS_EMPTY;
          end else begin
            load = 1'b0;
          end
        end
        default: begin
          out_status_nxt = STS_OK;
        end
      endcase
    end
    out_valid_nxt = load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= out_status_nxt;
      out_data_r   <= out_data_nxt;
      out_last_r   <= out_last_nxt;
      out_full_r   <= (count_nxt == CW'(CAPACITY));
      out_empty_r  <= (count_nxt == '0);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data     = out_data_r;
  assign out_last     = out_last_r;
  assign out_is_full  = out_full_r;
  assign out_is_empty = out_empty_r;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the bounded deque shift list: directed and random requests.
module testbench;
  import bdsl_pkg::*;

  localparam int CAPACITY = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_REQS = 400;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;
    logic               is_full;
    logic               is_empty;
  } list_rsp_t;

  typedef enum {DRIFT_UP, DRIFT_DOWN, DRIFT_EVEN} drift_t;

  logic clk;
  logic rst_n;

  bdsl_in_if  in_ch();
  bdsl_out_if out_ch();

  bounded_deque_shift_list_top #(.CAPACITY(CAPACITY)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // predicted list contents
  logic signed [31:0] list_vals [CAPACITY];
  int                 list_count;
  list_rsp_t          pending_results[$];

  int  req_count;
  int  rsp_count;
  int  mismatches;
  int  full_rejects;
  int  empty_rejects;
  int  readouts;
  int  idle_cycles;
  int  ready_hold;
  bit  no_idle;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic void expect_rsp(logic [1:0] status, logic signed [31:0] data,
                                     logic last);
    list_rsp_t r;
    r.status   = status;
    r.data     = data;
    r.last     = last;
    r.is_full  = (list_count >= CAPACITY);
    r.is_empty = (list_count == 0);
    pending_results.push_back(r);
  endfunction

  function automatic void apply_to_list(logic [2:0] op, logic signed [31:0] value);
    sts_t sts;
    int   i;
    sts = STS_OK;
    case (op)
      OP_INS_FRONT: begin
        if (list_count >= CAPACITY) sts = STS_FULL;
        else begin
          for (i = list_count; i > 0; i--) list_vals[i] = list_vals[i-1];
          list_vals[0] = value;
          list_count++;
        end
      end
      OP_INS_BACK: begin
        if (list_count >= CAPACITY) sts = STS_FULL;
        else begin
          list_vals[list_count] = value;
          list_count++;
        end
      end
      OP_REM_FRONT: begin
        if (list_count == 0) sts = STS_EMPTY;
        else begin
          for (i = 0; i + 1 < list_count; i++) list_vals[i] = list_vals[i+1];
          list_count--;
        end
      end
      OP_REM_BACK: begin
        if (list_count == 0) sts = STS_EMPTY;
        else list_count--;
      end
      OP_CLEAR: begin
        if (list_count == 0) sts = STS_EMPTY;
        else list_count = 0;
      end
      OP_READ: begin
        readouts++;
        if (list_count == 0) expect_rsp(STS_EMPTY, '0, 1'b1);
        else begin
          for (i = 0; i < list_count; i++)
            expect_rsp(STS_OK, list_vals[i], i == list_count - 1);
        end
        return;
      end
      default: ;
    endcase
    if (sts == STS_FULL) full_rejects++;
    if (sts == STS_EMPTY) empty_rejects++;
    expect_rsp(sts, '0, 1'b1);
  endfunction

  // request and result monitor, sampled at the rising edge
  always @(posedge clk) begin
    list_rsp_t got;
    list_rsp_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        req_count++;
        apply_to_list(in_ch.op, in_ch.value);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.status   = out_ch.status;
        got.data     = out_ch.data;
        got.last     = out_ch.last;
        got.is_full  = out_ch.is_full;
        got.is_empty = out_ch.is_empty;
        rsp_count++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result sts=%0d data=%0d last=%0b full=%0b empty=%0b",
                     got.status, got.data, got.last, got.is_full, got.is_empty);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.data !== want.data ||
              got.last !== want.last || got.is_full !== want.is_full ||
              got.is_empty !== want.is_empty) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d exp sts=%0d data=%0d last=%0b full=%0b empty=%0b %s",
                       rsp_count, want.status, want.data, want.last, want.is_full,
                       want.is_empty, "");
            if (mismatches <= 10)
              $display("       got sts=%0d data=%0d last=%0b full=%0b empty=%0b",
                       got.status, got.data, got.last, got.is_full, got.is_empty);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles, %0d results pending",
               idle_cycles, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    int stall;
    if (!rst_n) out_ch.ready = 1'b0;
    else if (no_idle) out_ch.ready = 1'b1;
    else if (ready_hold > 0) ready_hold--;
    else if (out_ch.ready) begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        ready_hold = stall - 1;
      end else ready_hold = $urandom_range(0, 6);
    end else begin
      out_ch.ready = 1'b1;
      ready_hold = $urandom_range(0, 6);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_request(logic [2:0] op, logic signed [31:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.op    = op;
    in_ch.value = value;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_op(drift_t drift);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return ($urandom_range(0, 1) != 0) ? OP_RSVD7 : OP_RSVD6;
    if (r < 6) return OP_CLEAR;
    if (r < 16) return OP_READ;
    case (drift)
      DRIFT_UP:   r = (r < 80) ? 0 : 1;
      DRIFT_DOWN: r = (r < 30) ? 0 : 1;
      default:    r = (r < 58) ? 0 : 1;
    endcase
    if (r == 0) return ($urandom_range(0, 1) != 0) ? OP_INS_FRONT : OP_INS_BACK;
    return ($urandom_range(0, 1) != 0) ? OP_REM_FRONT : OP_REM_BACK;
  endfunction

  task automatic test_empty_list();
    push_request(OP_READ, 32'sd1);
    push_request(OP_REM_FRONT, 32'sd2);
    push_request(OP_REM_BACK, 32'sd3);
    push_request(OP_CLEAR, 32'sd4);
    push_request(OP_RSVD6, 32'sh7fffffff);
    push_request(OP_RSVD7, 32'sh80000000);
  endtask

  task automatic test_fill_to_full();
    push_request(OP_INS_BACK, 32'sh7fffffff);
    push_request(OP_INS_FRONT, 32'sh80000000);
    push_request(OP_INS_BACK, 32'shaaaaaaaa);
    push_request(OP_INS_FRONT, 32'sh55555555);
    push_request(OP_INS_BACK, '0);
    push_request(OP_INS_FRONT, -32'sd1);
    push_request(OP_INS_BACK, 32'sd17);
    push_request(OP_INS_FRONT, -32'sd17);
    push_request(OP_INS_FRONT, 32'sd99);
    push_request(OP_INS_BACK, -32'sd99);
    push_request(OP_READ, '0);
  endtask

  task automatic test_drain();
    push_request(OP_REM_FRONT, '0);
    push_request(OP_REM_BACK, '0);
    push_request(OP_READ, '0);
    push_request(OP_CLEAR, '0);
    push_request(OP_READ, '0);
  endtask

  task automatic test_back_to_back();
    int n;
    no_idle = 1'b1;
    for (n = 0; n < 40; n++) push_request(pick_op(n < 20 ? DRIFT_UP : DRIFT_DOWN), rand_value());
    no_idle = 1'b0;
  endtask

  task automatic test_random_mix();
    int     sent;
    int     burst;
    drift_t drift;
    sent = 0;
    while (sent < RANDOM_REQS) begin
      case ($urandom_range(0, 2))
        0: drift = DRIFT_UP;
        1: drift = DRIFT_DOWN;
        default: drift = DRIFT_EVEN;
      endcase
      for (burst = $urandom_range(8, 30); burst > 0 && sent < RANDOM_REQS; burst--) begin
        push_request(pick_op(drift), rand_value());
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    no_idle = 1'b0;
    ready_hold = 0;
    list_count = 0;
    req_count = 0;
    rsp_count = 0;
    mismatches = 0;
    full_rejects = 0;
    empty_rejects = 0;
    readouts = 0;
    idle_cycles = 0;
    foreach (list_vals[i]) list_vals[i] = '0;
    @(negedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_list();
    test_fill_to_full();
    test_drain();
    test_back_to_back();
    test_random_mix();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;

    $display("Run covered %0d requests and %0d checked results, %0d read-outs.",
             req_count, rsp_count, readouts);
    $display("Rejected inserts on full list: %0d, requests on empty list: %0d, errors: %0d.",
             full_rejects, empty_rejects, mismatches);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== bounded_deque_shift_list_top.f =====
rtl/bdsl_pkg.sv
rtl/bdsl_if.sv
rtl/bdsl_ctrl.sv
rtl/bdsl_dp.sv
rtl/bounded_deque_shift_list_top.sv
tb/sv/testbench.sv
